FILE: hdl/sgkde_pkg.sv
// Shared types and constants for the symmetric Gaussian KDE block.
// Used by the top level and the checker.
package sgkde_pkg;

   localparam int DEF_MAX_SAMPLES    = 256;
   localparam int DEF_MAX_COMPONENTS = 8;

   localparam logic [1:0] REQ_SAMPLE   = 2'd0;
   localparam logic [1:0] REQ_LOCATION = 2'd1;
   localparam logic [1:0] REQ_WEIGHT   = 2'd2;
   localparam logic [1:0] REQ_QUERY    = 2'd3;

   localparam logic [1:0] CSR_ROWS  = 2'd0;
   localparam logic [1:0] CSR_COLS  = 2'd1;
   localparam logic [1:0] CSR_COEFF = 2'd2;
   localparam logic [1:0] CSR_SCALE = 2'd3;

   localparam logic [8:0]  ROWS_RESET  = 9'd1;
   localparam logic [3:0]  COLS_RESET  = 4'd1;
   localparam logic [31:0] COEFF_RESET = 32'd32768;
   localparam logic [31:0] SCALE_RESET = 32'd856722015;

   localparam logic [32:0] Q32_ONE    = 33'h1_0000_0000;
   localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
   localparam logic [48:0] ACC_LIMIT  = 49'h0_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         row_index;
      logic [2:0]         col_index;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] density;
      logic        saturated;
      logic        bad_index;
   } rsp_item_type;

endpackage

FILE: hdl/sgkde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sgkde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/symmetric_gaussian_kde.sv
// Top level of the symmetric Gaussian KDE block: stores, sequencer and shared multiplier.
// Depends on sgkde_pkg and sgkde_ram.
//
// Sample, location and weight writes raise no busy.
// A query walks every pair in use through one shared 32x32 multiplier; a full
// kernel evaluation is dominated by its 8 squarings, and a query keeps busy
// high until its result is shown. A bad query answers in the next cycle.
// The result is on rsp_item for exactly one cycle with rsp_valid high and
// cannot be held off by the receiver.
module symmetric_gaussian_kde
   import sgkde_pkg::*;
#(
   parameter int MAX_SAMPLES    = DEF_MAX_SAMPLES,
   parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int SA_W  = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;
   localparam int LA_W  = MAX_COMPONENTS > 1 ? $clog2(MAX_COMPONENTS) : 1;
   localparam int WDEP  = MAX_SAMPLES * MAX_COMPONENTS;
   localparam int WA_W  = WDEP > 1 ? $clog2(WDEP) : 1;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int MW    = $clog2(MAX_COMPONENTS + 1);

   typedef enum logic [24:0] {
      ST_IDLE = 25'h0000001, ST_U1  = 25'h0000002, ST_RD  = 25'h0000004,
      ST_U2   = 25'h0000008, ST_KABS = 25'h0000010, ST_KCL = 25'h0000020,
      ST_KCH  = 25'h0000040, ST_KT  = 25'h0000080, ST_H3  = 25'h0000100,
      ST_D3   = 25'h0000200, ST_P3  = 25'h0000400, ST_H2  = 25'h0000800,
      ST_P2   = 25'h0001000, ST_H1  = 25'h0002000, ST_P1  = 25'h0004000,
      ST_SQ   = 25'h0008000, ST_RND = 25'h0010000, ST_KEND = 25'h0020000,
      ST_TERM = 25'h0040000, ST_ACC = 25'h0080000, ST_F1  = 25'h0100000,
      ST_F2   = 25'h0200000, ST_F3  = 25'h0400000, ST_F4  = 25'h0800000,
      ST_F5   = 25'h1000000
   } state_type;

   state_type state_ff, state_in;
   logic [8:0]  rows_ff, rows_in;
   logic [3:0]  cols_ff, cols_in;
   logic [31:0] coeff_ff, coeff_in;
   logic [31:0] scale_ff, scale_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [32:0] u1_ff, u1_in;
   logic [33:0] d_ff, d_in, e_ff, e_in;
   logic [15:0] w_ff, w_in;
   logic        sel_ff, sel_in;
   logic [17:0] ksum_ff, ksum_in;
   logic [19:0] q_hi_ff, q_hi_in;
   logic [31:0] lo_ff, lo_in;
   logic [27:0] r_ff, r_in;
   logic [32:0] p_ff, p_in;
   logic [3:0]  sq_cnt_ff, sq_cnt_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [MW-1:0]    j_ff, j_in;
   logic [47:0] acc_ff, acc_in;
   logic        sat_ff, sat_in;
   logic [64:0] scr_ff, scr_in;
   logic [63:0] prod_ff;

   logic [31:0] mul_a, mul_b;
   logic [CNT_W-1:0] n_eff;
   logic [MW-1:0]    m_eff;
   logic        accept, bad_query;
   logic [SA_W-1:0] samp_rd_addr;
   logic [LA_W-1:0] loc_rd_addr;
   logic [WA_W-1:0] wgt_rd_addr, wgt_wr_addr;
   logic [31:0] samp_q, loc_q;
   logic [15:0] wgt_q;
   logic        samp_we, loc_we, wgt_we;

   logic [32:0] u2;
   logic [33:0] v, av;
   logic [52:0] t;
   logic [16:0] kv;
   logic [48:0] sum;
   logic [64:0] tot;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   always_comb begin
      if (32'(rows_ff) > MAX_SAMPLES) begin
         n_eff = CNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = CNT_W'(rows_ff);
      end
      if (32'(cols_ff) > MAX_COMPONENTS) begin
         m_eff = MW'(MAX_COMPONENTS);
      end else begin
         m_eff = MW'(cols_ff);
      end
   end

   assign bad_query = (32'(req_item.row_index) >= 32'(n_eff)) ||
                      (32'(req_item.col_index) >= 32'(m_eff));

   assign samp_we = accept && (req_item.req_type == REQ_SAMPLE) &&
                    (32'(req_item.row_index) < MAX_SAMPLES);
   assign loc_we  = accept && (req_item.req_type == REQ_LOCATION) &&
                    (32'(req_item.col_index) < MAX_COMPONENTS);
   assign wgt_we  = accept && (req_item.req_type == REQ_WEIGHT) &&
                    (32'(req_item.row_index) < MAX_SAMPLES) &&
                    (32'(req_item.col_index) < MAX_COMPONENTS);

   assign samp_rd_addr = (state_ff == ST_IDLE) ? SA_W'(req_item.row_index) : SA_W'(i_ff);
   assign loc_rd_addr  = (state_ff == ST_IDLE) ? LA_W'(req_item.col_index) : LA_W'(j_ff);
   assign wgt_rd_addr  = WA_W'(32'(i_ff) + 32'(j_ff) * MAX_SAMPLES);
   assign wgt_wr_addr  = WA_W'(32'(req_item.row_index) + 32'(req_item.col_index) * MAX_SAMPLES);

   sgkde_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_samples (
      .clock(clock), .wr_en(samp_we), .wr_addr(SA_W'(req_item.row_index)),
      .wr_data(req_item.value), .rd_addr(samp_rd_addr), .rd_data(samp_q)
   );

   sgkde_ram #(.WIDTH(32), .DEPTH(MAX_COMPONENTS)) u_locations (
      .clock(clock), .wr_en(loc_we), .wr_addr(LA_W'(req_item.col_index)),
      .wr_data(req_item.value), .rd_addr(loc_rd_addr), .rd_data(loc_q)
   );

   sgkde_ram #(.WIDTH(16), .DEPTH(WDEP)) u_weights (
      .clock(clock), .wr_en(wgt_we), .wr_addr(wgt_wr_addr),
      .wr_data(req_item.value[15:0]), .rd_addr(wgt_rd_addr), .rd_data(wgt_q)
   );

   always_comb begin
      state_in = state_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      coeff_in = coeff_ff;
      scale_in = scale_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in = rsp_item_ff;
      u1_in = u1_ff;
      d_in = d_ff;
      e_in = e_ff;
      w_in = w_ff;
      sel_in = sel_ff;
      ksum_in = ksum_ff;
      q_hi_in = q_hi_ff;
      lo_in = lo_ff;
      r_in = r_ff;
      p_in = p_ff;
      sq_cnt_in = sq_cnt_ff;
      i_in = i_ff;
      j_in = j_ff;
      acc_in = acc_ff;
      sat_in = sat_ff;
      scr_in = scr_ff;
      mul_a = '0;
      mul_b = '0;

      u2 = {samp_q[31], samp_q} - {loc_q[31], loc_q};
      v = sel_ff ? e_ff : d_ff;
      av = v[33] ? (34'd0 - v) : v;
      t = 53'(prod_ff[51:0]) + 53'(lo_ff);
      kv = 17'((p_ff + 33'h8000) >> 16);
      sum = 49'(acc_ff) + 49'(prod_ff[33:0]);
      tot = scr_ff + (65'(prod_ff) << 32);

      if (csr_write) begin
         case (csr_index)
            CSR_ROWS:  rows_in = csr_data[8:0];
            CSR_COLS:  cols_in = csr_data[3:0];
            CSR_COEFF: coeff_in = csr_data;
            CSR_SCALE: scale_in = csr_data;
            default:   rows_in = rows_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.req_type == REQ_QUERY)) begin
               if (bad_query) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in = '{density: 32'd0, saturated: 1'b0, bad_index: 1'b1};
               end else begin
                  acc_in = '0;
                  sat_in = 1'b0;
                  i_in = '0;
                  j_in = '0;
                  state_in = ST_U1;
               end
            end
         end
         ST_U1: begin
            u1_in = {samp_q[31], samp_q} - {loc_q[31], loc_q};
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_U2;
         end
         ST_U2: begin
            d_in = {u1_ff[32], u1_ff} - {u2[32], u2};
            e_in = 34'd0 - {u1_ff[32], u1_ff} - {u2[32], u2};
            w_in = wgt_q;
            ksum_in = '0;
            sel_in = 1'b0;
            state_in = ST_KABS;
         end
         ST_KABS: begin
            if (coeff_ff == 32'd0) begin
               p_in = Q32_ONE;
               state_in = ST_KEND;
            end else if (av[33:26] != 8'd0) begin
               p_in = '0;
               state_in = ST_KEND;
            end else begin
               mul_a = 32'(av[25:0]);
               mul_b = 32'(av[25:0]);
               state_in = ST_KCL;
            end
         end
         ST_KCL: begin
            q_hi_in = prod_ff[51:32];
            mul_a = coeff_ff;
            mul_b = prod_ff[31:0];
            state_in = ST_KCH;
         end
         ST_KCH: begin
            lo_in = prod_ff[63:32];
            mul_a = coeff_ff;
            mul_b = 32'(q_hi_ff);
            state_in = ST_KT;
         end
         ST_KT: begin
            if (t[52:20] != 33'd0) begin
               p_in = '0;
               state_in = ST_KEND;
            end else if (t == 53'd0) begin
               p_in = Q32_ONE;
               state_in = ST_KEND;
            end else begin
               r_in = {t[19:0], 8'd0};
               p_in = Q32_ONE - 33'({t[19:0], 6'd0});
               state_in = ST_H3;
            end
         end
         ST_H3, ST_H2, ST_H1: begin
            mul_a = 32'(r_ff);
            mul_b = p_ff[31:0];
            if (state_ff == ST_H3) begin
               state_in = ST_D3;
            end else if (state_ff == ST_H2) begin
               state_in = ST_P2;
            end else begin
               state_in = ST_P1;
            end
         end
         ST_D3: begin
            mul_a = prod_ff[63:32];
            mul_b = RECIP3;
            state_in = ST_P3;
         end
         ST_P3: begin
            p_in = Q32_ONE - 33'(prod_ff[63:33]);
            state_in = ST_H2;
         end
         ST_P2: begin
            p_in = Q32_ONE - 33'(prod_ff[63:33]);
            state_in = ST_H1;
         end
         ST_P1: begin
            p_in = Q32_ONE - 33'(prod_ff[63:32]);
            if (p_in[32]) begin
               p_in = Q32_ONE - 33'd1;
            end
            sq_cnt_in = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a = p_ff[31:0];
            mul_b = p_ff[31:0];
            state_in = ST_RND;
         end
         ST_RND: begin
            p_in = 33'((65'(prod_ff) + 65'h8000_0000) >> 32);
            sq_cnt_in = sq_cnt_ff + 4'd1;
            state_in = (sq_cnt_ff == 4'd7) ? ST_KEND : ST_SQ;
         end
         ST_KEND: begin
            ksum_in = ksum_ff + 18'(kv);
            if (!sel_ff) begin
               sel_in = 1'b1;
               state_in = ST_KABS;
            end else begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            mul_a = 32'(w_ff);
            mul_b = 32'(ksum_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sum > ACC_LIMIT) begin
               acc_in = ACC_LIMIT[47:0];
               sat_in = 1'b1;
            end else begin
               acc_in = sum[47:0];
            end
            state_in = ST_RD;
            if (32'(j_ff) + 32'd1 == 32'(m_eff)) begin
               j_in = '0;
               i_in = i_ff + CNT_W'(1);
               if (32'(i_ff) + 32'd1 == 32'(n_eff)) begin
                  state_in = ST_F1;
               end
            end else begin
               j_in = j_ff + MW'(1);
            end
         end
         ST_F1: begin
            mul_a = acc_ff[31:0];
            mul_b = 32'(scale_ff[15:0]);
            state_in = ST_F2;
         end
         ST_F2: begin
            scr_in = 65'(prod_ff >> 16);
            mul_a = 32'(acc_ff[47:32]);
            mul_b = 32'(scale_ff[15:0]);
            state_in = ST_F3;
         end
         ST_F3: begin
            scr_in = scr_ff + (65'(prod_ff) << 16);
            mul_a = acc_ff[31:0];
            mul_b = 32'(scale_ff[31:16]);
            state_in = ST_F4;
         end
         ST_F4: begin
            scr_in = scr_ff + 65'(prod_ff);
            mul_a = 32'(acc_ff[47:32]);
            mul_b = 32'(scale_ff[31:16]);
            state_in = ST_F5;
         end
         ST_F5: begin
            rsp_valid_in = 1'b1;
            rsp_item_in.bad_index = 1'b0;
            if (tot[64]) begin
               rsp_item_in.density = 32'hFFFF_FFFF;
               rsp_item_in.saturated = 1'b1;
            end else begin
               rsp_item_in.density = tot[63:32];
               rsp_item_in.saturated = sat_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
         coeff_ff <= COEFF_RESET;
         scale_ff <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         coeff_ff <= coeff_in;
         scale_ff <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      u1_ff <= u1_in;
      d_ff <= d_in;
      e_ff <= e_in;
      w_ff <= w_in;
      sel_ff <= sel_in;
      ksum_ff <= ksum_in;
      q_hi_ff <= q_hi_in;
      lo_ff <= lo_in;
      r_ff <= r_in;
      p_ff <= p_in;
      sq_cnt_ff <= sq_cnt_in;
      i_ff <= i_in;
      j_ff <= j_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      scr_ff <= scr_in;
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

FILE: hdl/sgkde_checker.sv
// Port-level checks for symmetric_gaussian_kde, attached by bind.
// Depends on sgkde_pkg.
module sgkde_checker
   import sgkde_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid,
   input rsp_item_type rsp_item,
   input logic         csr_write,
   input logic [1:0]   csr_index,
   input logic [31:0]  csr_data
);

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.req_type != REQ_QUERY) |=> !rsp_valid)
      else $error("write item produced a result");

   a_query_taken: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.req_type == REQ_QUERY) |=> rsp_valid || busy)
      else $error("query item neither answered nor in progress");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.bad_index |-> (rsp_item.density == 32'd0) && !rsp_item.saturated)
      else $error("bad index result carries data");

endmodule

bind symmetric_gaussian_kde sgkde_checker u_sgkde_checker (.*);
